FILE: rtl/tlscl_pkg.sv
package tlscl_pkg;

    // default sizing handed to the top level parameters
    localparam int LENGTH_BYTES_DEF = 3;
    localparam int INDEX_BITS_DEF   = 8;

    // byte role codes
    localparam logic [1:0] KIND_LIST_LEN = 2'd0;
    localparam logic [1:0] KIND_CERT_LEN = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD  = 2'd2;
    localparam logic [1:0] KIND_IGNORED  = 2'd3;

    // one tagged output item
    typedef struct packed {
        logic [1:0]  byte_kind;
        logic [7:0]  byte_out;
        logic [7:0]  cert_number;
        logic [23:0] cert_offset;
        logic        cert_last;
        logic        list_done;
        logic        list_error;
    } result_t;

endpackage

FILE: rtl/tlscl_parser.sv
module tlscl_parser #(
    parameter int LENGTH_BYTES = tlscl_pkg::LENGTH_BYTES_DEF,
    parameter int INDEX_BITS   = tlscl_pkg::INDEX_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          data_byte,
    input  logic                frame_start,
    output tlscl_pkg::result_t  result
);

    localparam int LEN_W  = 8 * LENGTH_BYTES;
    localparam int HC_W   = $clog2(LENGTH_BYTES + 1);
    localparam int CONS_W = LEN_W + 1;
    localparam int IDX_LIMIT_INT = (INDEX_BITS >= 8) ? 255 : ((1 << INDEX_BITS) - 1);
    localparam logic [INDEX_BITS-1:0] IDX_LIMIT = INDEX_BITS'(IDX_LIMIT_INT);
    localparam logic [HC_W-1:0] HC_FULL = HC_W'(LENGTH_BYTES);

    localparam logic [1:0] PH_LIST = 2'd0;
    localparam logic [1:0] PH_CERT = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]            phase_reg,     phase_next;
    logic [HC_W-1:0]       hcount_reg,    hcount_next;
    logic [LEN_W-1:0]      shift_reg,     shift_next;
    logic [LEN_W-1:0]      list_len_reg,  list_len_next;
    logic [CONS_W-1:0]     consumed_reg,  consumed_next;
    logic [LEN_W-1:0]      cert_len_reg,  cert_len_next;
    logic [LEN_W-1:0]      pay_cnt_reg,   pay_cnt_next;
    logic [INDEX_BITS-1:0] index_reg,     index_next;

    // state as seen by this item, a start flag wipes it first
    logic [1:0]            ph;
    logic [HC_W-1:0]       hc;
    logic [LEN_W-1:0]      sh;
    logic [LEN_W-1:0]      list_len;
    logic [CONS_W-1:0]     cons;
    logic [LEN_W-1:0]      cert_len;
    logic [LEN_W-1:0]      pay_cnt;
    logic [INDEX_BITS-1:0] idx;

    logic [LEN_W+7:0]      sh_wide;
    logic [LEN_W-1:0]      sh_in;
    logic [HC_W-1:0]       hc_inc;
    logic                  hdr_full;
    logic [CONS_W-1:0]     cons_inc;
    logic                  overrun;
    logic                  list_end;
    logic [LEN_W-1:0]      pay_inc;
    logic [INDEX_BITS-1:0] idx_sat;

    always_comb
    begin
        if (frame_start)
        begin
            ph       = PH_LIST;
            hc       = '0;
            sh       = '0;
            list_len = '0;
            cons     = '0;
            cert_len = '0;
            pay_cnt  = '0;
            idx      = '0;
        end
        else
        begin
            ph       = phase_reg;
            hc       = hcount_reg;
            sh       = shift_reg;
            list_len = list_len_reg;
            cons     = consumed_reg;
            cert_len = cert_len_reg;
            pay_cnt  = pay_cnt_reg;
            idx      = index_reg;
        end

        sh_wide  = {sh, data_byte};
        sh_in    = sh_wide[LEN_W-1:0];
        hc_inc   = hc + 1'b1;
        hdr_full = (hc_inc == HC_FULL);
        cons_inc = cons + 1'b1;
        overrun  = (cons_inc > {1'b0, list_len});
        list_end = (cons_inc >= {1'b0, list_len});
        pay_inc  = pay_cnt + 1'b1;
        idx_sat  = (idx < IDX_LIMIT) ? idx + 1'b1 : idx;

        phase_next    = ph;
        hcount_next   = hc;
        shift_next    = sh;
        list_len_next = list_len;
        consumed_next = cons;
        cert_len_next = cert_len;
        pay_cnt_next  = pay_cnt;
        index_next    = idx;

        result.byte_kind   = tlscl_pkg::KIND_IGNORED;
        result.byte_out    = data_byte;
        result.cert_number = '0;
        result.cert_offset = '0;
        result.cert_last   = 1'b0;
        result.list_done   = 1'b0;
        result.list_error  = 1'b0;

        case (ph)
            PH_LIST:
            begin
                result.byte_kind = tlscl_pkg::KIND_LIST_LEN;
                shift_next  = sh_in;
                hcount_next = hc_inc;
                if (hdr_full)
                begin
                    list_len_next = sh_in;
                    shift_next    = '0;
                    hcount_next   = '0;
                    if (sh_in == '0)
                    begin
                        result.list_done = 1'b1;
                        phase_next       = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_CERT;
                    end
                end
            end
            PH_CERT:
            begin
                result.byte_kind   = tlscl_pkg::KIND_CERT_LEN;
                result.cert_number = 8'(idx);
                consumed_next = cons_inc;
                shift_next    = sh_in;
                hcount_next   = hc_inc;
                if (overrun)
                begin
                    result.list_error = 1'b1;
                    result.list_done  = 1'b1;
                    phase_next        = PH_DONE;
                end
                else if (hdr_full)
                begin
                    cert_len_next = sh_in;
                    shift_next    = '0;
                    hcount_next   = '0;
                    pay_cnt_next  = '0;
                    if (sh_in == '0)
                    begin
                        // empty certificate ends on its last length byte
                        result.cert_last = 1'b1;
                        index_next       = idx_sat;
                        result.list_done = list_end;
                        phase_next       = list_end ? PH_DONE : PH_CERT;
                    end
                    else
                    begin
                        phase_next = PH_PAY;
                    end
                end
            end
            PH_PAY:
            begin
                result.byte_kind   = tlscl_pkg::KIND_PAYLOAD;
                result.cert_number = 8'(idx);
                result.cert_offset = 24'(pay_cnt);
                consumed_next = cons_inc;
                pay_cnt_next  = pay_inc;
                if (overrun)
                begin
                    result.list_error = 1'b1;
                    result.list_done  = 1'b1;
                    phase_next        = PH_DONE;
                end
                else if (pay_inc >= cert_len)
                begin
                    result.cert_last = 1'b1;
                    index_next       = idx_sat;
                    hcount_next      = '0;
                    shift_next       = '0;
                    pay_cnt_next     = '0;
                    result.list_done = list_end;
                    phase_next       = list_end ? PH_DONE : PH_CERT;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LIST;
            hcount_reg   <= '0;
            shift_reg    <= '0;
            list_len_reg <= '0;
            consumed_reg <= '0;
            cert_len_reg <= '0;
            pay_cnt_reg  <= '0;
            index_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            hcount_reg   <= hcount_next;
            shift_reg    <= shift_next;
            list_len_reg <= list_len_next;
            consumed_reg <= consumed_next;
            cert_len_reg <= cert_len_next;
            pay_cnt_reg  <= pay_cnt_next;
            index_reg    <= index_next;
        end
    end

endmodule

FILE: rtl/tls_certificate_list_deframer.sv
// an accepted byte is held in the input register, then in the result register
// as the tagged item; throughput: one byte per cycle unless m_axis_tready stalls
// it, set by the single-step parser update between the two registers
// reset: rst_n (asynchronous, active low) empties both registers and puts
// the parser in the list header phase with all counters at zero
module tls_certificate_list_deframer #(
    parameter int LENGTH_BYTES = tlscl_pkg::LENGTH_BYTES_DEF,
    parameter int INDEX_BITS   = tlscl_pkg::INDEX_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] frame_start
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] byte_out, [15:8] cert_number,
                                        // [39:16] cert_offset
    output logic [3:0]  m_axis_tuser,   // [1:0] byte_kind, [2] cert_last,
                                        // [3] list_error
    output logic        m_axis_tlast    // list_done
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_data_reg;
    logic       in_start_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    tlscl_pkg::result_t out_reg;
    tlscl_pkg::result_t step_result;

    logic s_accept;
    logic advance;

    // the held item moves on when the result slot is free or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_data_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser[0];
        end
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    // parser state advances once per item leaving the input register
    tlscl_parser #(
        .LENGTH_BYTES (LENGTH_BYTES),
        .INDEX_BITS   (INDEX_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .data_byte   (in_data_reg),
        .frame_start (in_start_reg),
        .result      (step_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.cert_offset, out_reg.cert_number, out_reg.byte_out};
    assign m_axis_tuser  = {out_reg.list_error, out_reg.cert_last, out_reg.byte_kind};
    assign m_axis_tlast  = out_reg.list_done;

    // an overrun always closes the list and never closes a certificate
    a_error_closes_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.list_error |-> out_reg.list_done && !out_reg.cert_last)
        else $error("list error without list done or with cert last");

    // ignored bytes carry no certificate tags
    a_ignored_untagged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.byte_kind == tlscl_pkg::KIND_IGNORED
        |-> out_reg.cert_number == 8'd0 && out_reg.cert_offset == 24'd0
            && !out_reg.cert_last && !out_reg.list_done)
        else $error("ignored byte carries tags");

    // only payload bytes have an offset
    a_offset_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.cert_offset != 24'd0
        |-> out_reg.byte_kind == tlscl_pkg::KIND_PAYLOAD)
        else $error("offset on a non-payload byte");

    // a list length byte belongs to no certificate
    a_list_len_untagged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.byte_kind == tlscl_pkg::KIND_LIST_LEN
        |-> out_reg.cert_number == 8'd0 && !out_reg.cert_last && !out_reg.list_error)
        else $error("list length byte tagged as certificate");

    // a parser step only happens with a held item and space downstream
    a_step_has_space: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> in_valid_reg && (!out_valid_reg || m_axis_tready))
        else $error("parser stepped without room for the result");

endmodule
